FILE: rtl/gbr_pkg.sv
`default_nettype none
package gbr_pkg;
	localparam int XPointsDefault = 64;
	localparam int YPointsDefault = 64;
	localparam int CoordW = 32;
	localparam int DistW = 34;

	typedef enum logic [1:0] {
		OP_LOAD_X = 2'd0,
		OP_LOAD_Y = 2'd1,
		OP_LOAD_Z = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_XGAP   = 3'd1,
		REG_YGAP   = 3'd2,
		REG_XCOUNT = 3'd3,
		REG_YCOUNT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        hv;
		logic        lv;
		logic [33:0] hd;
		logic [33:0] ld;
	} srch_t;
endpackage
`default_nettype wire

FILE: rtl/gbr_cell.sv
`default_nettype none
module gbr_cell (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [31:0]       wdata,
	input  wire logic              shift,
	input  wire logic [31:0]       prev_coord,
	output logic      [31:0]       coord
);
	logic [31:0] coord_q;
	assign coord = coord_q;
	always_ff @(posedge clk) begin
		if (we) begin
			coord_q <= wdata;
		end else if (shift) begin
			coord_q <= prev_coord;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/gbr_axis.sv
`default_nettype none
module gbr_axis
	import gbr_pkg::*;
#(
	parameter int N = 64,
	parameter int IW = $clog2(N)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ld_en,
	input  wire logic [IW-1:0]     ld_idx,
	input  wire logic [31:0]       ld_val,
	input  wire logic              start,
	input  wire logic [10:0]       cnt,
	input  wire logic              mode,
	input  wire logic signed [31:0] q,
	input  wire logic signed [31:0] gap,
	output logic                   done,
	output logic                   found,
	output logic [IW-1:0]          lo,
	output logic [IW-1:0]          hi,
	output logic signed [31:0]     c_lo,
	output logic signed [31:0]     c_hi,
	output logic                   both
);
	logic [31:0] cc [N];
	logic        rot;
	logic [10:0] k_q;
	logic        busy_q;
	srch_t       s_q;
	logic [IW-1:0] hk_q, lk_q;
	logic [31:0] hc_q, lc_q;
	logic signed [33:0] diff, d;
	logic        ok, hup, lup;

	// ring of cells; rotates once per step so that cell 0 presents entry k
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic wr;
		assign wr = ld_en && !busy_q && (ld_idx == IW'(i));
		gbr_cell u_cell (
			.clk(clk), .we(wr), .wdata(ld_val), .shift(rot),
			.prev_coord(cc[(i + 1) % N]), .coord(cc[i]));
	end

	logic [10:0] lim;
	assign lim = (cnt > 11'(N)) ? 11'(N) : cnt;
	assign rot = busy_q;

	always_comb begin
		diff = 34'(q) - 34'(signed'(cc[0]));
		d = diff[33] ? -diff : diff;
		ok = !(!gap[31] && d > 34'(gap));
		if (!mode) begin
			hup = 1'b0;
			lup = !s_q.lv || (s_q.ld > d);
		end else begin
			hup = ok && diff[33] && (!s_q.hv || s_q.hd > d);
			lup = ok && !diff[33] && (!s_q.lv || s_q.ld > d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			done <= 1'b0;
			s_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
				s_q <= '0;
			end else if (busy_q) begin
				if (k_q < lim) begin
					if (hup) begin
						s_q.hv <= 1'b1;
						s_q.hd <= d;
					end
					if (lup) begin
						s_q.lv <= 1'b1;
						s_q.ld <= d;
					end
				end
				k_q <= k_q + 11'd1;
				if (k_q == 11'(N - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && k_q < lim) begin
			if (hup) begin
				hk_q <= k_q[IW-1:0];
				hc_q <= cc[0];
			end
			if (lup) begin
				lk_q <= k_q[IW-1:0];
				lc_q <= cc[0];
			end
		end
	end

	logic nm_ok;
	assign nm_ok = !(!gap[31] && s_q.ld > 34'(gap));
	always_comb begin
		if (!mode) begin
			found = s_q.lv && nm_ok;
			lo = lk_q;
			hi = lk_q;
			c_lo = lc_q;
			c_hi = lc_q;
			both = 1'b0;
		end else begin
			found = s_q.hv || s_q.lv;
			both = s_q.hv && s_q.lv;
			lo = s_q.lv ? lk_q : hk_q;
			hi = s_q.hv ? hk_q : lk_q;
			c_lo = s_q.lv ? lc_q : hc_q;
			c_hi = s_q.hv ? hc_q : lc_q;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/gbr_div.sv
`default_nettype none
module gbr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,
	input  wire logic [32:0] den,
	output logic             done,
	output logic [15:0]      quo
);
	logic [49:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0]  n_q;
	logic        busy_q;
	logic [49:0] trial;
	logic [32:0] den_q;
	assign quo = quo_q;
	// restoring division of num*65536 by den; num < den, so 16 quotient bits
	always_comb trial = {rem_q[48:0], 1'b0} - {17'd0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= '0;
			end else if (busy_q) begin
				n_q <= n_q + 5'd1;
				if (n_q == 5'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {17'd0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!trial[49]) begin
				rem_q <= trial;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[48:0], 1'b0};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/grid_bilinear_resampler.sv
`default_nettype none
// Query flow: an accepted query runs parallel ring scans, one step per entry; on a hit
// there follow two parallel 16-step divisions, four z-memory reads and three lerp
// multiplies, while a gap skips them. One query at a time: input holds until the result
// is taken.
// Reset: arst_n clears control and config registers (mode 1, gaps -1, counts 64);
// coordinate and z stores are undefined until written.
module grid_bilinear_resampler
	import gbr_pkg::*;
#(
	parameter int X_POINTS = XPointsDefault,
	parameter int Y_POINTS = YPointsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[1:0], col_index[7:2], row_index[13:8], load_value[45:14],
	// query_x[77:46], query_y[109:78], zero fill
	input  wire logic [111:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// result_value[31:0], is_gap[32], zero fill
	output logic [39:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int XW = $clog2(X_POINTS);
	localparam int YW = $clog2(Y_POINTS);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001, ST_SCAN = 9'b000000010, ST_DIV = 9'b000000100,
		ST_RD   = 9'b000001000, ST_MX   = 9'b000010000, ST_AX = 9'b000100000,
		ST_MY   = 9'b001000000, ST_AY = 9'b010000000, ST_OUT = 9'b100000000
	} st_t;
	st_t st_q;

	logic        mode_q;
	logic [31:0] xgap_q, ygap_q;
	logic [6:0]  xcnt_q, ycnt_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1; xgap_q <= '1; ygap_q <= '1;
			xcnt_q <= 7'd64; ycnt_q <= 7'd64;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:   mode_q <= cfg_data[0];
				REG_XGAP:   xgap_q <= cfg_data;
				REG_YGAP:   ygap_q <= cfg_data;
				REG_XCOUNT: xcnt_q <= cfg_data[6:0];
				REG_YCOUNT: ycnt_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	logic [1:0]  op;
	logic [5:0]  col, row;
	logic [31:0] lval, qx, qy;
	assign op = s_axis_tdata[1:0];
	assign col = s_axis_tdata[7:2];
	assign row = s_axis_tdata[13:8];
	assign lval = s_axis_tdata[45:14];
	assign qx = s_axis_tdata[77:46];
	assign qy = s_axis_tdata[109:78];

	logic acc;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [31:0] qx_q, qy_q;
	logic        start;
	assign start = acc && (op == OP_QUERY);
	always_ff @(posedge clk) if (start) begin
		qx_q <= qx; qy_q <= qy;
	end

	logic xdone, xfound, xboth, ydone, yfound, yboth;
	logic [XW-1:0] xlo, xhi;
	logic [YW-1:0] ylo, yhi;
	logic signed [31:0] xcl, xch, ycl, ych;
	logic xld, yld;
	assign xld = acc && (op == OP_LOAD_X) && (32'(col) < X_POINTS);
	assign yld = acc && (op == OP_LOAD_Y) && (32'(row) < Y_POINTS);

	gbr_axis #(.N(X_POINTS), .IW(XW)) u_x (
		.clk(clk), .arst_n(arst_n), .ld_en(xld), .ld_idx(XW'(col)), .ld_val(lval),
		.start(start), .cnt({4'd0, xcnt_q}), .mode(mode_q), .q(qx_q), .gap(xgap_q),
		.done(xdone), .found(xfound), .lo(xlo), .hi(xhi), .c_lo(xcl), .c_hi(xch),
		.both(xboth));
	gbr_axis #(.N(Y_POINTS), .IW(YW)) u_y (
		.clk(clk), .arst_n(arst_n), .ld_en(yld), .ld_idx(YW'(row)), .ld_val(lval),
		.start(start), .cnt({4'd0, ycnt_q}), .mode(mode_q), .q(qy_q), .gap(ygap_q),
		.done(ydone), .found(yfound), .lo(ylo), .hi(yhi), .c_lo(ycl), .c_hi(ych),
		.both(yboth));

	logic        dstart, xdd, ydd;
	logic [15:0] fx, fy;
	gbr_div u_dx (.clk(clk), .arst_n(arst_n), .start(dstart),
		.num(33'(signed'(qx_q)) - 33'(signed'(xcl))),
		.den(33'(signed'(xch)) - 33'(signed'(xcl))), .done(xdd), .quo(fx));
	gbr_div u_dy (.clk(clk), .arst_n(arst_n), .start(dstart),
		.num(33'(signed'(qy_q)) - 33'(signed'(ycl))),
		.den(33'(signed'(ych)) - 33'(signed'(ycl))), .done(ydd), .quo(fy));
	logic [15:0] fx_q, fy_q;

	logic [31:0] zmem [X_POINTS*Y_POINTS];
	localparam int ZW = $clog2(X_POINTS*Y_POINTS);
	logic [ZW-1:0] zaddr;
	logic [31:0]   zrd_q;
	logic [2:0]    r_q;
	logic [XW-1:0] zc;
	logic [YW-1:0] zr;
	always_comb begin
		zc = r_q[0] ? xhi : xlo;
		zr = r_q[1] ? yhi : ylo;
	end
	assign zaddr = ZW'(32'(zc) * Y_POINTS + 32'(zr));
	always_ff @(posedge clk) begin
		if (acc && op == OP_LOAD_Z && 32'(col) < X_POINTS && 32'(row) < Y_POINTS)
			zmem[ZW'(32'(col) * Y_POINTS + 32'(row))] <= lval;
		zrd_q <= zmem[zaddr];
	end

	logic signed [31:0] z_q [4];
	logic signed [31:0] a_q, b_q, l0_q;
	logic [15:0]        f_q;
	logic signed [49:0] p_s1;
	logic signed [49:0] pp;
	logic signed [33:0] s;
	logic [1:0]         ph_q;
	logic [31:0]        res_q;
	logic               gap_q, xs_q, ys_q;

	always_comb begin
		pp = p_s1 + 50'sd32768;
		s = 34'(pp >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; dstart <= 1'b0; xs_q <= 1'b0; ys_q <= 1'b0;
			r_q <= '0; ph_q <= '0;
		end else begin
			dstart <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) begin
					st_q <= ST_SCAN; xs_q <= 1'b0; ys_q <= 1'b0;
				end
				ST_SCAN: begin
					if ((xs_q || xdone) && (ys_q || ydone)) begin
						if (!xfound || !yfound) begin
							gap_q <= 1'b1; res_q <= '0; st_q <= ST_OUT;
						end else begin
							gap_q <= 1'b0; dstart <= 1'b1; st_q <= ST_DIV;
							xs_q <= 1'b0; ys_q <= 1'b0;
						end
					end else begin
						if (xdone) xs_q <= 1'b1;
						if (ydone) ys_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (xdd) xs_q <= 1'b1;
					if (ydd) ys_q <= 1'b1;
					if ((xs_q || xdd) && (ys_q || ydd)) begin
						fx_q <= xboth ? fx : 16'd0;
						fy_q <= yboth ? fy : 16'd0;
						r_q <= '0; st_q <= ST_RD;
					end
				end
				ST_RD: begin
					r_q <= r_q + 3'd1;
					if (r_q != 3'd0) z_q[r_q[1:0] - 2'd1] <= zrd_q;
					if (r_q == 3'd4) begin
						ph_q <= '0; st_q <= ST_MX;
					end
				end
				ST_MX: begin
					unique case (ph_q)
						2'd0: begin a_q <= z_q[0]; b_q <= z_q[1]; f_q <= fx_q; end
						2'd1: begin a_q <= z_q[2]; b_q <= z_q[3]; f_q <= fx_q; end
						default: begin a_q <= l0_q; b_q <= res_q; f_q <= fy_q; end
					endcase
					st_q <= ST_AX;
				end
				ST_AX: begin
					p_s1 <= (50'(b_q) - 50'(a_q)) * signed'({34'd0, f_q});
					st_q <= ST_AY;
				end
				ST_AY: begin
					if (ph_q == 2'd0) l0_q <= 32'(34'(a_q) + s);
					else res_q <= 32'(34'(a_q) + s);
					if (ph_q == 2'd2) st_q <= ST_OUT;
					else begin
						ph_q <= ph_q + 2'd1; st_q <= ST_MX;
					end
				end
				ST_MY: st_q <= ST_OUT;
				ST_OUT: if (m_axis_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {7'd0, gap_q, res_q};
endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import gbr_pkg::*;

	localparam int SettleCycles = XPointsDefault + YPointsDefault + 100;

	typedef struct {
		logic [31:0] value;
		logic        gap;
	} answer_t;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [31:0] data;
		op_t         op;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [31:0] val;
		logic [31:0] qx;
		logic [31:0] qy;
		bit          typed;
		logic [31:0] tv;
		logic        tg;
	} row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [39:0]  m_axis_tdata;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	logic signed [31:0] x_pts [64];
	logic signed [31:0] y_pts [64];
	logic signed [31:0] z_vals [64][64];
	bit          nn_mode;
	longint      x_gap;
	longint      y_gap;
	int          x_cnt;
	int          y_cnt;

	answer_t     pending_answers[$];
	row_t        directed[$];
	int          fails = 0;
	int          words_sent = 0;
	bit          calm = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	grid_bilinear_resampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint coord(bit ax, int k);
		return ax ? longint'(y_pts[k]) : longint'(x_pts[k]);
	endfunction

	function automatic bit bracket(bit ax, longint q, output int lo, output int hi,
			output longint fr);
		int     cnt;
		longint gap, diff, d, bd, hd, ld;
		bit     hv, lv;
		int     hk, lk, best;
		cnt = ax ? y_cnt : x_cnt;
		if (cnt > 64)
			cnt = 64;
		gap = ax ? y_gap : x_gap;
		fr = 0;
		lo = 0;
		hi = 0;
		if (nn_mode) begin
			if (cnt == 0)
				return 0;
			best = 0;
			bd = q - coord(ax, 0);
			if (bd < 0)
				bd = -bd;
			for (int k = 1; k < cnt; k++) begin
				d = q - coord(ax, k);
				if (d < 0)
					d = -d;
				if (bd > d) begin
					best = k;
					bd = d;
				end
			end
			if (gap >= 0 && bd > gap)
				return 0;
			lo = best;
			hi = best;
			return 1;
		end
		hv = 0;
		lv = 0;
		hk = 0;
		lk = 0;
		hd = 0;
		ld = 0;
		for (int k = 0; k < cnt; k++) begin
			diff = q - coord(ax, k);
			d = diff < 0 ? -diff : diff;
			if (!(gap >= 0 && d > gap)) begin
				if (diff < 0) begin
					if (!hv || hd > d) begin
						hv = 1;
						hk = k;
						hd = d;
					end
				end else begin
					if (!lv || ld > d) begin
						lv = 1;
						lk = k;
						ld = d;
					end
				end
			end
		end
		if (!hv && !lv)
			return 0;
		if (hv && lv) begin
			lo = lk;
			hi = hk;
			fr = ((q - coord(ax, lk)) <<< 16) / (coord(ax, hk) - coord(ax, lk));
		end else begin
			lo = lv ? lk : hk;
			hi = lo;
		end
		return 1;
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		longint p;
		p = (b - a) * f + 32768;
		return a + (p >>> 16);
	endfunction

	function automatic answer_t resample(logic [31:0] qx, logic [31:0] qy);
		answer_t r;
		int      xl, xh, yl, yh;
		longint  fx, fy, z;
		if (!bracket(0, longint'(signed'(qx)), xl, xh, fx) ||
				!bracket(1, longint'(signed'(qy)), yl, yh, fy)) begin
			r.value = '0;
			r.gap = 1;
			return r;
		end
		z = blend(blend(z_vals[xl][yl], z_vals[xh][yl], fx),
			blend(z_vals[xl][yh], z_vals[xh][yh], fx), fy);
		r.value = z[31:0];
		r.gap = 0;
		return r;
	endfunction

	task automatic send(op_t op, logic [5:0] col, logic [5:0] row, logic [31:0] val,
			logic [31:0] qx, logic [31:0] qy, bit typed = 0, logic [31:0] tv = 0,
			logic tg = 0);
		int      n;
		answer_t a;
		n = calm ? 0 : $urandom_range(0, 5);
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {2'b0, qy, qx, val, row, col, op};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		case (op)
			OP_LOAD_X: x_pts[col] = val;
			OP_LOAD_Y: y_pts[row] = val;
			OP_LOAD_Z: z_vals[col][row] = val;
			default: begin
				if (typed) begin
					a.value = tv;
					a.gap = tg;
				end else begin
					a = resample(qx, qy);
				end
				pending_answers.push_back(a);
			end
		endcase
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_MODE:   nn_mode = !d[0];
			REG_XGAP:   x_gap = longint'(signed'(d));
			REG_YGAP:   y_gap = longint'(signed'(d));
			REG_XCOUNT: x_cnt = d[6:0];
			REG_YCOUNT: y_cnt = d[6:0];
			default: ;
		endcase
	endtask

	// Points 8..63 repeat points 0..7, so the earliest index always wins and
	// only the 8x8 corner of the z grid is ever read.
	task automatic set_point(bit ax, int j, logic [31:0] v);
		for (int m = 0; m < 8; m++) begin
			if (ax)
				send(OP_LOAD_Y, 6'($urandom), 6'(j + 8 * m), v, $urandom, $urandom);
			else
				send(OP_LOAD_X, 6'(j + 8 * m), 6'($urandom), v, $urandom, $urandom);
		end
	endtask

	function automatic logic [31:0] seed_point(int j);
		if (j == 0)
			return 32'h8000_0000;
		if (j == 7)
			return 32'h7FFF_FFFF;
		return j << 16;
	endfunction

	function automatic logic [31:0] aim(bit ax);
		if ($urandom_range(0, 9) < 2)
			return $urandom;
		return 32'(coord(ax, $urandom_range(0, 7))) + $urandom_range(0, 32'h40000) - 32'h20000;
	endfunction

	function automatic logic [31:0] pick_gap();
		case ($urandom_range(0, 3))
			0: return $urandom | 32'h8000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h30000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 64;
			2: return 127;
			3: return $urandom_range(0, 127);
			default: return $urandom_range(1, 10) | ($urandom & 32'hFFFF_FF80);
		endcase
	endfunction

	function automatic row_t item_row(op_t op, logic [5:0] col, logic [5:0] row,
			logic [31:0] val, logic [31:0] qx, logic [31:0] qy, bit typed = 0,
			logic [31:0] tv = 0, logic tg = 0);
		row_t r;
		r.is_cfg = 0;
		r.idx = REG_MODE;
		r.data = '0;
		r.op = op;
		r.col = col;
		r.row = row;
		r.val = val;
		r.qx = qx;
		r.qy = qy;
		r.typed = typed;
		r.tv = tv;
		r.tg = tg;
		return r;
	endfunction

	function automatic row_t cfg_row(reg_idx_t idx, logic [31:0] d);
		row_t r;
		r.is_cfg = 1;
		r.idx = idx;
		r.data = d;
		r.op = OP_LOAD_X;
		r.col = '0;
		r.row = '0;
		r.val = '0;
		r.qx = '0;
		r.qy = '0;
		r.typed = 0;
		r.tv = '0;
		r.tg = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result word %h", m_axis_tdata);
				fails++;
			end else begin
				a = pending_answers.pop_front();
				if (m_axis_tdata[31:0] !== a.value) begin
					$error("result_value expected %h got %h", a.value, m_axis_tdata[31:0]);
					fails++;
				end
				if (m_axis_tdata[32] !== a.gap) begin
					$error("is_gap expected %b got %b", a.gap, m_axis_tdata[32]);
					fails++;
				end
			end
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		#50_000_000;
		$display("[grid_bilinear_resampler] ERROR");
		$finish;
	end

	initial begin
		int    target;
		row_t  r;
		nn_mode = 0;
		x_gap = -1;
		y_gap = -1;
		x_cnt = 64;
		y_cnt = 64;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int j = 0; j < 8; j++) begin
			set_point(0, j, seed_point(j));
			set_point(1, j, seed_point(j));
		end
		for (int c = 0; c < 8; c++)
			for (int w = 0; w < 8; w++)
				send(OP_LOAD_Z, 6'(c), 6'(w), (c == 0 && w == 0) ? 32'h8000_0000 :
					(c == 7 && w == 7) ? 32'h7FFF_FFFF : (c * 8 + w) << 16,
					$urandom, $urandom);

		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h30000, 32'h50000,
			1, 32'h001D_0000, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1, 32'h7FFF_FFFF, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
			1, 32'h8000_0000, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h28000, 32'h14000));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h4000_0000, 32'hC000_0000));
		directed.push_back(cfg_row(REG_MODE, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h36666, 32'h5999A));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h38000, 32'h18000));
		directed.push_back(cfg_row(REG_XGAP, 32'h8000));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h3C000, 32'h20000));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h4000_0000, 32'h20000,
			1, 0, 1));
		directed.push_back(cfg_row(REG_XCOUNT, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h30000, 32'h30000, 1, 0, 1));
		directed.push_back(cfg_row(REG_XCOUNT, 127));
		directed.push_back(cfg_row(REG_YCOUNT, 1));
		directed.push_back(cfg_row(REG_MODE, 1));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h31000, 32'h50000));
		directed.push_back(cfg_row(REG_YGAP, 0));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h30000, 32'h50000, 1, 0, 1));
		directed.push_back(item_row(OP_LOAD_Z, 63, 63, 32'hFFFF_FFFF, 0, 0));
		directed.push_back(cfg_row(REG_XGAP, 32'hFFFF_FFFF));
		directed.push_back(cfg_row(REG_YGAP, 32'h8000_0000));
		directed.push_back(cfg_row(REG_YCOUNT, 64));
		directed.push_back(item_row(OP_QUERY, 0, 0, 0, 32'h2C000, 32'h6C000));

		foreach (directed[i]) begin
			r = directed[i];
			if (r.is_cfg)
				write_reg(r.idx, r.data);
			else
				send(r.op, r.col, r.row, r.val, r.qx, r.qy, r.typed, r.tv, r.tg);
		end

		for (int ph = 0; ph < 8; ph++) begin
			calm = ph % 3 == 2;
			write_reg(REG_MODE, $urandom);
			write_reg(REG_XGAP, pick_gap());
			write_reg(REG_YGAP, pick_gap());
			write_reg(REG_XCOUNT, pick_count());
			write_reg(REG_YCOUNT, pick_count());
			target = words_sent + 140;
			while (words_sent < target) begin
				case ($urandom_range(0, 19))
					0, 1: set_point(1'($urandom_range(0, 1)), $urandom_range(0, 7),
						$urandom_range(0, 3) == 0 ? $urandom :
						$urandom_range(0, 32'hC0000) - 32'h60000);
					2, 3, 4: send(OP_LOAD_Z, 6'($urandom), 6'($urandom), $urandom,
						$urandom, $urandom);
					default: send(OP_QUERY, 6'($urandom), 6'($urandom), $urandom,
						aim(0), aim(1));
				endcase
			end
		end

		drain();
		if (fails == 0)
			$display("[grid_bilinear_resampler] OK");
		else
			$display("[grid_bilinear_resampler] ERROR");
		$finish;
	end
endmodule
